[sv/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } itoa_state_t;

    localparam int unsigned CHAR_W = 7;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    localparam logic       MODE_SIGNED   = 1'b0;
    localparam logic       MODE_UNSIGNED = 1'b1;

    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;
    localparam logic [3:0] BCD_MAX     = 4'd9;

endpackage

[sv/itoa_if.sv]
// ----------------------------------------------------------------------------
// itoa_in_if / itoa_out_if
// Number and text channels of the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
interface itoa_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [VALUE_WIDTH-1:0] value_bits;

    modport source (output valid, output mode, output value_bits, input ready);
    modport sink   (input valid, input mode, input value_bits, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

[sv/int_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_unit
// Converts a signed or unsigned integer into decimal ASCII characters,
// most significant first, with a leading minus for negative signed values.
// ----------------------------------------------------------------------------
//  channel   dir   payload                 request
//  number    in    mode, value_bits        one integer to convert
//  text      out   text_char, last_char    one character of the number
//
//  one request goes through the load, the shift-add-3 unit over VALUE_WIDTH bits
//  and the leading zero skip, then one cycle per character sent while text.ready
//  is high (11 characters at most at 32 bits)
//  the binary to BCD loop handles one magnitude bit per cycle
//  number.ready is high only while idle; text stalls simply hold the character
//  rst_n clears the sequencer asynchronously
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_unit
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    number,
    itoa_out_if.source text
);

    localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int BCNT_W = $clog2(VALUE_WIDTH);
    localparam int DCNT_W = $clog2(NDIG + 1);

    itoa_state_t              state_reg, state_next;
    logic [VALUE_WIDTH-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]         bcd_reg, bcd_next;
    logic [BCNT_W-1:0]        bcnt_reg, bcnt_next;
    logic [DCNT_W-1:0]        dcnt_reg, dcnt_next;
    logic                     neg_reg, neg_next;

    logic                     accept;
    logic                     neg_in;
    logic [VALUE_WIDTH-1:0]   mag_in;
    logic [BCD_W-1:0]         bcd_adj;
    logic [3:0]               top_digit;
    logic                     last_digit;

    assign accept     = number.valid && number.ready;
    assign neg_in     = (number.mode == MODE_SIGNED) && number.value_bits[VALUE_WIDTH-1];
    assign mag_in     = neg_in ? (~number.value_bits + {{(VALUE_WIDTH-1){1'b0}}, 1'b1})
                               : number.value_bits;
    assign top_digit  = bcd_reg[BCD_W-1 -: 4];
    assign last_digit = (dcnt_reg == DCNT_W'(1));

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= BCD_ADJ_MIN)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + BCD_ADJ_ADD;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (bcnt_reg == '0)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (!(top_digit == 4'd0 && !last_digit))
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (text.ready)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (text.ready && last_digit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        number.ready   = 1'b0;
        text.valid     = 1'b0;
        text.text_char = CHAR_ZERO;
        text.last_char = 1'b0;
        unique case (state_reg)
            ST_IDLE: number.ready = 1'b1;
            ST_SIGN:
            begin
                text.valid     = 1'b1;
                text.text_char = CHAR_MINUS;
            end
            ST_EMIT:
            begin
                text.valid     = 1'b1;
                text.text_char = CHAR_ZERO + {3'b000, top_digit};
                text.last_char = last_digit;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        bcnt_next = bcnt_reg;
        dcnt_next = dcnt_reg;
        neg_next  = neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next  = mag_in;
                    neg_next  = neg_in;
                    bcd_next  = '0;
                    bcnt_next = BCNT_W'(VALUE_WIDTH - 1);
                    dcnt_next = DCNT_W'(NDIG);
                end
            end
            ST_CONV:
            begin
                bcd_next  = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next  = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bcnt_next = bcnt_reg - BCNT_W'(1);
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && !last_digit)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (text.ready && !last_digit)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bcnt_reg  <= '0;
            dcnt_reg  <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bcnt_reg  <= bcnt_next;
            dcnt_reg  <= dcnt_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        number.ready |-> !text.valid)
        else $error("input taken while a character is pending");

    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CONV)
        else $error("conversion did not start after request");

    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && bcnt_reg == '0) |=> state_reg == ST_SKIP)
        else $error("conversion ran past the last bit");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> top_digit <= BCD_MAX)
        else $error("digit out of decimal range");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && text.last_char) |=> state_reg == ST_IDLE)
        else $error("no return to idle after last character");
`endif

endmodule

[bench/tb_int_to_decimal_ascii_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int_to_decimal_ascii_unit
// Self-checking bench for the integer to decimal ASCII converter. A directed
// table covers zero, sign and magnitude extremes and digit-count boundaries,
// then random numbers follow. Every character sent back is compared in order
// with the text predicted for each accepted request, while both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_int_to_decimal_ascii_unit;

    import itoa_pkg::*;

    localparam int VALUE_W    = 32;
    localparam int RAND_ITEMS = 310;
    localparam int DIR_ROWS   = 22;
    localparam int MAX_SHOWN  = 10;

    localparam logic [87:0] NO_TEXT = 88'd0;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] value;
        logic [87:0]        text;
    } dir_row_t;

    // text is filled in only where it is obvious, the rest is predicted
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{MODE_SIGNED,   32'h0000_0000, "0"},
        '{MODE_UNSIGNED, 32'h0000_0000, "0"},
        '{MODE_SIGNED,   32'hFFFF_FFFF, "-1"},
        '{MODE_SIGNED,   32'h7FFF_FFFF, "2147483647"},
        '{MODE_SIGNED,   32'h8000_0000, "-2147483648"},
        '{MODE_UNSIGNED, 32'h8000_0000, "2147483648"},
        '{MODE_UNSIGNED, 32'hFFFF_FFFF, "4294967295"},
        '{MODE_UNSIGNED, 32'h7FFF_FFFF, NO_TEXT},
        '{MODE_SIGNED,   32'h8000_0001, NO_TEXT},
        '{MODE_SIGNED,   32'd1,         NO_TEXT},
        '{MODE_SIGNED,   32'd9,         NO_TEXT},
        '{MODE_SIGNED,   32'd10,        NO_TEXT},
        '{MODE_UNSIGNED, 32'd99,        NO_TEXT},
        '{MODE_UNSIGNED, 32'd100,       NO_TEXT},
        '{MODE_SIGNED,   32'hFFFF_FFF7, NO_TEXT},
        '{MODE_SIGNED,   32'hFFFF_FFF6, NO_TEXT},
        '{MODE_UNSIGNED, 32'hFFFF_FFF6, NO_TEXT},
        '{MODE_UNSIGNED, 32'd999999999, NO_TEXT},
        '{MODE_UNSIGNED, 32'd1000000000, NO_TEXT},
        '{MODE_SIGNED,   32'hAAAA_AAAA, NO_TEXT},
        '{MODE_UNSIGNED, 32'hAAAA_AAAA, NO_TEXT},
        '{MODE_SIGNED,   32'h5555_5555, NO_TEXT}
    };

    logic clk;
    logic rst_n;

    itoa_in_if #(.VALUE_WIDTH(VALUE_W)) number_if ();
    itoa_out_if                         text_if ();

    int_to_decimal_ascii_unit #(
        .VALUE_WIDTH(VALUE_W)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if),
        .text   (text_if)
    );

    text_char_t pending_chars [$];
    int         fail_count;
    int         numbers_sent;
    int         chars_checked;
    int         negatives_sent;
    int         top_bit_unsigned;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int draw_pause(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // decimal text of one request, sign first, no leading zeros
    function automatic void predict_text(logic mode, logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  digits [$];
        logic               neg;
        text_char_t         c;
        neg = (mode == MODE_SIGNED) && value[VALUE_W-1];
        mag = neg ? (~value + 1'b1) : value;
        do
        begin
            digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        if (neg)
        begin
            c.ch   = CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.insert(pending_chars.size(), c);
        end
        foreach (digits[i])
        begin
            c.ch   = digits[i];
            c.last = (i == digits.size() - 1);
            pending_chars.insert(pending_chars.size(), c);
        end
    endfunction

    function automatic void expect_literal(logic [87:0] txt);
        text_char_t c;
        for (int b = 10; b >= 0; b--)
        begin
            if (txt[b*8 +: 8] != 8'd0)
            begin
                c.ch   = txt[b*8 +: CHAR_W];
                c.last = (b == 0);
                pending_chars.insert(pending_chars.size(), c);
            end
        end
    endfunction

    function automatic void report_fail(string what);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    int send_calm;

    task automatic send_number(logic mode, logic [VALUE_W-1:0] value, logic [87:0] txt);
        int gap;
        gap = draw_pause(send_calm);
        if (gap > 0)
        begin
            number_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        number_if.valid      <= 1'b1;
        number_if.mode       <= mode;
        number_if.value_bits <= value;
        @(posedge clk);
        while (!number_if.ready)
            @(posedge clk);
        if (txt != NO_TEXT)
            expect_literal(txt);
        else
            predict_text(mode, value);
        numbers_sent++;
        if (mode == MODE_SIGNED && value[VALUE_W-1])
            negatives_sent++;
        if (mode == MODE_UNSIGNED && value[VALUE_W-1])
            top_bit_unsigned++;
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] p;
        p = 1;
        case ($urandom_range(0, 7))
            0: return VALUE_W'($urandom_range(0, 20));
            1: return VALUE_W'(0) - VALUE_W'($urandom_range(1, 20));
            2, 3:
            begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                p = p + VALUE_W'($urandom_range(0, 2)) - 1'b1;
                return ($urandom_range(0, 1) == 0) ? p : (~p + 1'b1);
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h8000_0001;
                endcase
            end
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    // text side: random back-pressure, in-order check
    initial
    begin
        int         stall;
        int         calm;
        text_char_t want;
        calm = 0;
        text_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_pause(calm);
            if (stall > 0)
            begin
                text_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            text_if.ready <= 1'b1;
            @(posedge clk);
            while (!text_if.valid)
                @(posedge clk);
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                report_fail($sformatf("unexpected char %0d last %0b",
                                      text_if.text_char, text_if.last_char));
            end
            else
            begin
                want = pending_chars.pop_front();
                if (text_if.text_char !== want.ch || text_if.last_char !== want.last)
                    report_fail($sformatf("char exp %0d last %0b, got %0d last %0b",
                                          want.ch, want.last,
                                          text_if.text_char, text_if.last_char));
            end
        end
    end

    initial
    begin
        logic mode;
        fail_count       = 0;
        numbers_sent     = 0;
        chars_checked    = 0;
        negatives_sent   = 0;
        top_bit_unsigned = 0;
        send_calm        = 0;
        rst_n                <= 1'b0;
        number_if.valid      <= 1'b0;
        number_if.mode       <= MODE_SIGNED;
        number_if.value_bits <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_number(DIRECTED[i].mode, DIRECTED[i].value, DIRECTED[i].text);

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            mode = ($urandom_range(0, 1) == 0) ? MODE_SIGNED : MODE_UNSIGNED;
            send_number(mode, random_value(), NO_TEXT);
        end
        number_if.valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (pending_chars.size() != 0)
            report_fail($sformatf("%0d chars never arrived", pending_chars.size()));

        $display("converted %0d numbers (%0d negative, %0d unsigned with top bit set)",
                 numbers_sent, negatives_sent, top_bit_unsigned);
        $display("checked %0d characters, %0d mismatches", chars_checked, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
